>>> hdl/sha1_pkg.sv
`default_nettype none
package sha1_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned DIGEST_WORDS = 5;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    FN_CHOOSE,
    FN_PARITY_A,
    FN_MAJORITY,
    FN_PARITY_B
  } round_fn_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {v, v} << n;
    return dbl[63:32];
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha1_message_digest_top.sv
`default_nettype none
// Channel  | Valid      | Stall      | Payload
// ---------+------------+------------+----------------------------------------
// input    | in_valid   | in_stall   | data_byte, has_byte, is_last
// output   | out_valid  | out_stall  | digest_word, word_index, last_word
//
// A plain byte beat does not stall the input. The beat that fills a 64-byte
// block stalls the input while it is compressed: 80 rounds on the single
// round adder, then a fold of the working words into the chaining words.
// A last beat adds 9 to 72 pad/length bytes, one or two compressions,
// and five output beats. rst is synchronous; it restores the initial chaining
// words and a zero bit count. A stalled output holds its word and index.
module sha1_message_digest_top
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  state_t      state, state_next;

  // Message schedule window, also the block buffer: word 0 sits in the top bits.
  logic [511:0] sched;
  logic [63:0]  bit_count;
  logic [63:0]  len_bits;
  logic [31:0]  chain [DIGEST_WORDS];
  logic [31:0]  ra, rb, rc, rd, re;
  logic [6:0]   rnd;
  logic         padding;   // message closed, pad/length in progress
  logic         mark;      // 0x80 still to be appended
  logic         lenph;     // length bytes being appended
  logic [2:0]   word_idx;

  logic         in_acc, out_acc;
  logic         absorb_en;
  logic [7:0]   absorb_byte;
  logic [5:0]   pos;
  logic         blk_full;
  logic [63:0]  len_shift;
  logic [31:0]  w0, w2, w8, w13, w_new;
  logic [31:0]  f, k, tmp;
  round_fn_t    fn;

  assign pos       = bit_count[8:3];
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign len_shift = len_bits << {pos[2:0], 3'b000};
  assign blk_full  = absorb_en && (pos == 6'(BLOCK_BYTES - 1));

  assign w0  = sched[511:480];
  assign w2  = sched[447:416];
  assign w8  = sched[255:224];
  assign w13 = sched[95:64];
  assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 5'd1);

  // Round function selection by round range.
  always_comb begin
    if (rnd < 7'd20)      fn = FN_CHOOSE;
    else if (rnd < 7'd40) fn = FN_PARITY_A;
    else if (rnd < 7'd60) fn = FN_MAJORITY;
    else                  fn = FN_PARITY_B;
  end

  always_comb begin
    unique case (fn)
      FN_CHOOSE: begin
        f = (rb & rc) | (~rb & rd);
        k = K0;
      end
      FN_PARITY_A: begin
        f = rb ^ rc ^ rd;
        k = K1;
      end
      FN_MAJORITY: begin
        f = (rb & rc) | (rb & rd) | (rc & rd);
        k = K2;
      end
      default: begin
        f = rb ^ rc ^ rd;
        k = K3;
      end
    endcase
  end

  assign tmp = rotl(ra, 5'd5) + f + re + k + w0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_byte && (pos == 6'(BLOCK_BYTES - 1))) state_next = ST_COMPRESS;
          else if (is_last)                             state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos == 6'(BLOCK_BYTES - 1)) state_next = ST_COMPRESS;
      end
      ST_COMPRESS: begin
        if (rnd == 7'(ROUNDS)) begin
          if (!padding)  state_next = ST_IDLE;
          else if (lenph) state_next = ST_OUT;
          else            state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_acc && (word_idx == 3'(DIGEST_WORDS - 1))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    absorb_en   = 1'b0;
    absorb_byte = data_byte;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        absorb_en = in_valid && has_byte;
      end
      ST_PAD: begin
        absorb_en = 1'b1;
        if (mark)                                 absorb_byte = PAD_MARK;
        else if (lenph || pos == 6'(LEN_POS))     absorb_byte = len_shift[63:56];
        else                                      absorb_byte = 8'h00;
      end
      ST_COMPRESS: begin
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      bit_count <= '0;
      chain[0] <= H0;
      chain[1] <= H1;
      chain[2] <= H2;
      chain[3] <= H3;
      chain[4] <= H4;
      rnd      <= '0;
      padding  <= 1'b0;
      mark     <= 1'b0;
      lenph    <= 1'b0;
      word_idx <= '0;
    end else begin
      state <= state_next;

      if (absorb_en) begin
        sched     <= {sched[503:0], absorb_byte};
        bit_count <= bit_count + 64'd8;
      end

      if (blk_full) begin
        rnd <= '0;
        ra  <= chain[0];
        rb  <= chain[1];
        rc  <= chain[2];
        rd  <= chain[3];
        re  <= chain[4];
      end

      if (in_acc && is_last) begin
        padding  <= 1'b1;
        mark     <= 1'b1;
        lenph    <= 1'b0;
        len_bits <= has_byte ? bit_count + 64'd8 : bit_count;
      end

      if (state == ST_PAD) begin
        mark <= 1'b0;
        if (!mark && pos == 6'(LEN_POS)) lenph <= 1'b1;
      end

      if (state == ST_COMPRESS) begin
        if (rnd != 7'(ROUNDS)) begin
          ra    <= tmp;
          rb    <= ra;
          rc    <= rotl(rb, 5'd30);
          rd    <= rc;
          re    <= rd;
          sched <= {sched[479:0], w_new};
          rnd   <= rnd + 7'd1;
        end else begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          chain[4] <= chain[4] + re;
        end
      end

      if (out_acc) begin
        if (word_idx == 3'(DIGEST_WORDS - 1)) begin
          word_idx  <= '0;
          padding   <= 1'b0;
          lenph     <= 1'b0;
          bit_count <= '0;
          chain[0]  <= H0;
          chain[1]  <= H1;
          chain[2]  <= H2;
          chain[3]  <= H3;
          chain[4]  <= H4;
        end else begin
          word_idx <= word_idx + 3'd1;
        end
      end
    end
  end

  always_comb begin
    unique case (word_idx)
      3'd0:    digest_word = chain[0];
      3'd1:    digest_word = chain[1];
      3'd2:    digest_word = chain[2];
      3'd3:    digest_word = chain[3];
      default: digest_word = chain[4];
    endcase
  end

  assign word_index = word_idx;
  assign last_word  = (word_idx == 3'(DIGEST_WORDS - 1));

endmodule
`default_nettype wire

>>> sim/sha1_digest_checker.sv
module sha1_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        is_last,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] digest_word,
  input  wire logic [2:0]  word_index,
  input  wire logic        last_word,
  output int unsigned      words_owed,
  output int unsigned      words_checked,
  output int unsigned      mismatch_count
);

  localparam logic [159:0] CHAIN_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0]   PAD_BYTE = 8'h80;
  localparam logic [5:0]   LEN_SLOT = 6'd56;
  localparam logic [5:0]   TAIL_SLOT = 6'd63;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic [31:0]  chain [5];
  logic [7:0]   blk [64];
  logic [63:0]  msg_bits;
  digest_beat_t owed_words [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] ERROR %s: got %h, want %h", $time, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  function automatic void start_message();
    int i;
    for (i = 0; i < 5; i++) chain[i] = CHAIN_IV[159 - 32 * i -: 32];
    msg_bits = '0;
  endfunction

  // 80 rounds over the current block, rolling 16-word schedule
  function automatic void run_rounds();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, mix, sum;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        mix = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        w[r % 16] = {mix[30:0], mix[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function automatic void hash_in_byte(input logic [7:0] v);
    logic [5:0] slot;
    slot = msg_bits[8:3];
    blk[slot] = v;
    msg_bits = msg_bits + 64'd8;
    if (slot == TAIL_SLOT) run_rounds();
  endfunction

  // pad, append the length, queue the five digest words, restart
  function automatic void close_message();
    logic [63:0]  len_bits;
    digest_beat_t beat;
    int i;
    len_bits = msg_bits;
    hash_in_byte(PAD_BYTE);
    while (msg_bits[8:3] != LEN_SLOT) hash_in_byte(8'h00);
    for (i = 7; i >= 0; i--) hash_in_byte(len_bits[8 * i +: 8]);
    for (i = 0; i < 5; i++) begin
      beat.word = chain[i];
      beat.idx  = 3'(i);
      beat.fin  = (i == 4);
      owed_words = {owed_words, beat};
    end
    start_message();
  endfunction

  // outputs first: a beat accepted now cannot stem from an input taken now
  always @(posedge clk) begin : watch
    digest_beat_t want;
    if (rst) begin
      start_message();
      owed_words.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        words_checked = words_checked + 1;
        if (owed_words.size() == 0) begin
          report_mismatch("digest beat with nothing owed", digest_word, '0);
        end else begin
          want = owed_words.pop_front();
          if (digest_word !== want.word)
            report_mismatch($sformatf("digest_word %0d", want.idx), digest_word, want.word);
          if (word_index !== want.idx)
            report_mismatch($sformatf("word_index %0d", want.idx), 32'(word_index),
                            32'(want.idx));
          if (last_word !== want.fin)
            report_mismatch($sformatf("last_word %0d", want.idx), 32'(last_word),
                            32'(want.fin));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (has_byte) hash_in_byte(data_byte);
        if (is_last) close_message();
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

>>> sim/tb.sv
module tb;

  // beats carrying a byte or a last mark; empty beats don't count
  localparam int unsigned RAND_ITEMS   = 480;
  // long output hold so the digest backs up into the input side
  localparam int unsigned HOLD_CYCLES  = 600;
  // worst tail after the last beat: 72 pad bytes, two compressions, 5 words
  localparam int unsigned DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte  = 1'b0;
  logic        is_last   = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // traffic shaping, in percent per cycle
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_go     = 1'b0;
  logic        holding     = 1'b0;

  int unsigned msgs_sent  = 0;
  int unsigned items_sent = 0;
  int unsigned bytes_sent = 0;

  int unsigned words_owed;
  int unsigned words_checked;
  int unsigned mismatch_count;

  sha1_message_digest_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .has_byte    (has_byte),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // predicts digests from accepted input beats, checks every output beat
  sha1_digest_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .words_owed     (words_owed),
    .words_checked  (words_checked),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, or a solid stall while the long hold runs.
  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(99) < rx_idle_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until
  // taken. Valid stays high straight into the next beat when no gap follows.
  task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    is_last   <= lst;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (hb || lst) items_sent++;
    if (hb) bytes_sent++;
    if (lst) msgs_sent++;
  endtask

  // A message of len bytes with random content. The last mark either rides
  // on the final byte or comes as its own empty beat; an empty message always
  // ends with an empty last beat. Empty beats sprinkled in as noise.
  task automatic send_message(input int unsigned len, input logic split_last);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !split_last);
    end
    if (len == 0 || split_last) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Mostly short messages; a good share sit on the padding edges where the
  // length field spills into a second block, and a few span several blocks.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(20);
    if (r < 85) begin
      case ($urandom_range(7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    if (r < 96) return $urandom_range(54, 21);
    return $urandom_range(140, 100);
  endfunction

  initial begin
    int unsigned start_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, single extreme bytes with the last mark on
    // them, "abc" with empty beats in between, a message whose last mark
    // arrives on an empty beat after the bytes, and another empty message.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'hC3, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);

    // Random: three traffic phases by item count; the long output hold
    // fires once at the start of the free-running phase.
    start_items = items_sent;
    while (items_sent - start_items < RAND_ITEMS) begin
      if (items_sent - start_items >= 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b1;
      end else if (items_sent - start_items >= RAND_ITEMS / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 8;
        rx_idle_pct = 59;
      end
      send_message(pick_len(), 1'($urandom_range(1)));
    end
    in_valid <= 1'b0;

    // owed count is registered from the checker's queue size, so let it settle first
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages from %0d beats (%0d bytes); %0d digest words checked.",
             msgs_sent, items_sent, bytes_sent, words_checked);
    $display("Traffic: sender/receiver idle 8/59, then 59/8, then none, with a %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d digest words still owed", words_owed);
    $display("Mismatches found");
    $finish;
  end

endmodule
